@@ rtl/core/ohcihc_pkg.sv @@
// OHCI host controller register file: shared constants, types and helpers.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package ohcihc_pkg;

    // defaults for the top-level parameters
    localparam int DEF_REG_WORDS     = 64;
    localparam int DEF_BIT_TIMES     = 12000;
    localparam int DEF_NUM_PORTS     = 4;

    localparam int IDX_W             = 6;
    localparam int ELAPSED_W         = 14;
    localparam int ADDR_SPACE        = 64;

    // transaction opcodes
    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // register word offsets
    localparam logic [IDX_W-1:0] R_REV   = 6'd0;
    localparam logic [IDX_W-1:0] R_CTRL  = 6'd1;
    localparam logic [IDX_W-1:0] R_CMD   = 6'd2;
    localparam logic [IDX_W-1:0] R_IST   = 6'd3;
    localparam logic [IDX_W-1:0] R_IEN   = 6'd4;
    localparam logic [IDX_W-1:0] R_IDIS  = 6'd5;
    localparam logic [IDX_W-1:0] R_HCCA  = 6'd6;
    localparam logic [IDX_W-1:0] R_PCED  = 6'd7;
    localparam logic [IDX_W-1:0] R_CHED  = 6'd8;
    localparam logic [IDX_W-1:0] R_CCED  = 6'd9;
    localparam logic [IDX_W-1:0] R_BHED  = 6'd10;
    localparam logic [IDX_W-1:0] R_BCED  = 6'd11;
    localparam logic [IDX_W-1:0] R_DONE  = 6'd12;
    localparam logic [IDX_W-1:0] R_FMI   = 6'd13;
    localparam logic [IDX_W-1:0] R_FMR   = 6'd14;
    localparam logic [IDX_W-1:0] R_FMN   = 6'd15;
    localparam logic [IDX_W-1:0] R_PSTRT = 6'd16;
    localparam logic [IDX_W-1:0] R_LST   = 6'd17;
    localparam logic [IDX_W-1:0] R_RHDA  = 6'd18;
    localparam logic [IDX_W-1:0] R_RHDB  = 6'd19;
    localparam logic [IDX_W-1:0] R_RHST  = 6'd20;
    localparam int               R_PORT0 = 21;

    // functional states (Control.HCFS)
    localparam logic [1:0] HCFS_RESET = 2'd0;
    localparam logic [1:0] HCFS_OPER  = 2'd2;
    localparam logic [1:0] HCFS_SUSP  = 2'd3;

    // reset values
    localparam logic [31:0] REV_VAL       = 32'h0000_0010;
    localparam logic [31:0] FMI_DEF       = 32'h2778_2EDF;
    localparam logic [31:0] LST_DEF       = 32'h0000_0628;
    localparam logic [31:0] RH_NO_PWR_SW  = 32'h0000_0200;
    localparam logic [31:0] RH_NO_OC_PROT = 32'h0000_1000;

    // ports that actually fit in the register store
    function automatic int np_eff(input int reg_words, input int num_ports);
        return (num_ports < reg_words - R_PORT0) ? num_ports : reg_words - R_PORT0;
    endfunction

    // write request into the general word store
    typedef struct packed {
        logic              en;
        logic              clr;
        logic [IDX_W-1:0]  idx;
        logic [31:0]       data;
    } store_wr_t;

    // read request into the general word store
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
    } store_rd_t;

endpackage

@@ rtl/core/ohcihc_if.sv @@
// Handshake channels of the OHCI register file: request and response.
// Depends on ohcihc_pkg for field widths.
`timescale 1ns / 1ps

interface ohcihc_req_if;
    import ohcihc_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          opcode;
    logic [IDX_W-1:0]    reg_index;
    logic [31:0]         write_data;

    modport source (output valid, output opcode, output reg_index, output write_data,
                    input ready);
    modport sink   (input valid, input opcode, input reg_index, input write_data,
                    output ready);
endinterface

interface ohcihc_rsp_if;
    logic                valid;
    logic                ready;
    logic [31:0]         read_data;
    logic                irq_level;

    modport source (output valid, output read_data, output irq_level, input ready);
    modport sink   (input valid, input read_data, input irq_level, output ready);
endinterface

@@ rtl/core/ohcihc_gen_store.sv @@
// General-purpose register words above the root-hub ports: memory plus valid bits.
// Depends on ohcihc_pkg (store request structs, np_eff).
`timescale 1ns / 1ps

module ohcihc_gen_store
    import ohcihc_pkg::*;
#(
    parameter int REG_WORDS = DEF_REG_WORDS,
    parameter int NUM_PORTS = DEF_NUM_PORTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  store_wr_t   wr,
    input  store_rd_t   rd,
    output logic [31:0] rdata
);

    localparam int MEM_BASE  = R_PORT0 + np_eff(REG_WORDS, NUM_PORTS);
    localparam int MEM_TOP   = (REG_WORDS < ADDR_SPACE) ? REG_WORDS : ADDR_SPACE;
    localparam int MEM_DEPTH = (MEM_TOP > MEM_BASE) ? MEM_TOP - MEM_BASE : 0;
    localparam int ALLOC     = (MEM_DEPTH < 1) ? 1 : MEM_DEPTH;
    localparam int AW        = (ALLOC > 1) ? $clog2(ALLOC) : 1;

    logic [31:0]      mem [ALLOC];
    logic [ALLOC-1:0] valid_reg;
    logic [31:0]      data_reg;
    logic [AW-1:0]    addr_reg;
    logic             hit_reg;

    logic             wr_hit;
    logic             rd_hit;
    logic [IDX_W:0]   wr_off;
    logic [IDX_W:0]   rd_off;

    assign wr_off = {1'b0, wr.idx} - (IDX_W+1)'(MEM_BASE);
    assign rd_off = {1'b0, rd.idx} - (IDX_W+1)'(MEM_BASE);
    assign wr_hit = ({1'b0, wr.idx} >= (IDX_W+1)'(MEM_BASE)) &&
                    ({1'b0, wr.idx} <  (IDX_W+1)'(MEM_TOP));
    assign rd_hit = ({1'b0, rd.idx} >= (IDX_W+1)'(MEM_BASE)) &&
                    ({1'b0, rd.idx} <  (IDX_W+1)'(MEM_TOP));

    always_ff @(posedge clk)
    begin
        if (wr.en && wr_hit)
        begin
            mem[wr_off[AW-1:0]] <= wr.data;
        end
    end

    // read with same-edge write bypass
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            if (wr.en && wr_hit && rd_hit && (wr.idx == rd.idx))
            begin
                data_reg <= wr.data;
            end
            else
            begin
                data_reg <= mem[rd_off[AW-1:0]];
            end
            addr_reg <= rd_off[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr.clr)
            begin
                valid_reg <= '0;
            end
            else if (wr.en && wr_hit)
            begin
                valid_reg[wr_off[AW-1:0]] <= 1'b1;
            end
            if (rd.en)
            begin
                hit_reg <= rd_hit;
            end
        end
    end

    assign rdata = (hit_reg && valid_reg[addr_reg]) ? data_reg : 32'd0;

endmodule

@@ rtl/core/ohci_host_controller_registers.sv @@
// OHCI host controller register file: bus reads/writes and bit-time ticks.
// Latency: an accepted request transaction passes the input reg, then the result reg,
// which drives the response; a stalled response holds it in the input reg.
// Throughput: one transaction per cycle unless rsp stalls; single-pass masked updates.
// Reset (rst_n, async, active low): all registers to OHCI defaults, frame counter
// stopped and cleared, irq low. General store words clear via valid bits at once.
// Depends on ohcihc_pkg, ohcihc_if, ohcihc_gen_store.
`timescale 1ns / 1ps

module ohci_host_controller_registers
    import ohcihc_pkg::*;
#(
    parameter int REG_WORDS           = DEF_REG_WORDS,
    parameter int BIT_TIMES_PER_FRAME = DEF_BIT_TIMES,
    parameter int NUM_PORTS           = DEF_NUM_PORTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    ohcihc_req_if.sink  req,
    ohcihc_rsp_if.source rsp
);

    // root-hub ports that exist in the store; port word i sits at R_PORT0 + i
    localparam int NP = np_eff(REG_WORDS, NUM_PORTS);
    localparam int PW = (NP > 1) ? $clog2(NP) : 1;
    localparam logic [31:0] RHDA_DEF = RH_NO_PWR_SW | RH_NO_OC_PROT | 32'(NUM_PORTS & 8'hFF);

    // ---------------------------------------------------------------
    // Input register (stage 1)
    // ---------------------------------------------------------------
    logic              s1_valid_reg;
    logic [1:0]        s1_op_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic [31:0]       s1_data_reg;
    logic              s1_fire;
    logic              req_acc;

    assign s1_fire = s1_valid_reg && (!rsp.valid || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_fire;
    assign req_acc = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            s1_op_reg   <= req.opcode;
            s1_idx_reg  <= req.reg_index;
            s1_data_reg <= req.write_data;
        end
    end

    // ---------------------------------------------------------------
    // Architectural registers. Words that never change (Revision,
    // PeriodCurrentED, DoneHead, FmNumber) are constants. InterruptStatus
    // can only ever hold SF and RhStatus only DRWE, so only those bits live.
    // ---------------------------------------------------------------
    logic [31:0]          ctrl_reg,  ctrl_next;
    logic [3:0]           cmd_reg,   cmd_next;
    logic                 sf_reg,    sf_next;
    logic [31:0]          ien_reg,   ien_next;
    logic [23:0]          hcca_reg,  hcca_next;
    logic [27:0]          ched_reg,  ched_next;
    logic [27:0]          cced_reg,  cced_next;
    logic [27:0]          bhed_reg,  bhed_next;
    logic [27:0]          bced_reg,  bced_next;
    logic [31:0]          fmi_reg,   fmi_next;
    logic [ELAPSED_W-1:0] fmr_reg,   fmr_next;
    logic [31:0]          pstrt_reg, pstrt_next;
    logic [31:0]          lst_reg,   lst_next;
    logic [31:0]          rhda_reg,  rhda_next;
    logic [31:0]          rhdb_reg,  rhdb_next;
    logic                 drwe_reg,  drwe_next;
    logic [31:0]          port_reg  [NP];
    logic [31:0]          port_next [NP];
    logic                 run_reg,   run_next;
    logic [ELAPSED_W-1:0] elap_reg,  elap_next;
    logic                 irq_reg,   irq_next;

    // general store above the ports
    store_wr_t   st_wr;
    store_rd_t   st_rd;
    logic        st_wr_en;
    logic [31:0] st_rdata;

    assign st_rd.en  = req_acc;
    assign st_rd.idx = req.reg_index;

    ohcihc_gen_store #(
        .REG_WORDS (REG_WORDS),
        .NUM_PORTS (NUM_PORTS)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (st_wr),
        .rd    (st_rd),
        .rdata (st_rdata)
    );

    // ---------------------------------------------------------------
    // Single-pass update for the transaction held in stage 1
    // ---------------------------------------------------------------
    logic [31:0]          rd_val;
    logic [31:0]          v;
    logic [IDX_W-1:0]     pofs;
    logic                 port_hit;
    logic [PW-1:0]        pidx;
    logic                 hard_rst;
    logic                 soft_rst;
    logic                 st_clr;
    logic [ELAPSED_W:0]   elap_inc;
    logic                 pwr_ok;

    assign v        = s1_data_reg;
    assign pofs     = s1_idx_reg - IDX_W'(R_PORT0);
    assign port_hit = ({1'b0, s1_idx_reg} >= (IDX_W+1)'(R_PORT0)) &&
                      ({1'b0, pofs} < (IDX_W+1)'(NP));
    assign pidx     = pofs[PW-1:0];
    assign elap_inc = {1'b0, elap_reg} + (ELAPSED_W+1)'(1);
    // power switching only in ganged (PSM clear) or per-port mode, never with NPS
    assign pwr_ok   = !rhda_reg[9];

    always_comb
    begin
        ctrl_next  = ctrl_reg;
        cmd_next   = cmd_reg;
        sf_next    = sf_reg;
        ien_next   = ien_reg;
        hcca_next  = hcca_reg;
        ched_next  = ched_reg;
        cced_next  = cced_reg;
        bhed_next  = bhed_reg;
        bced_next  = bced_reg;
        fmi_next   = fmi_reg;
        fmr_next   = fmr_reg;
        pstrt_next = pstrt_reg;
        lst_next   = lst_reg;
        rhda_next  = rhda_reg;
        rhdb_next  = rhdb_reg;
        drwe_next  = drwe_reg;
        port_next  = port_reg;
        run_next   = run_reg;
        elap_next  = elap_reg;
        irq_next   = irq_reg;
        rd_val     = 32'd0;
        hard_rst   = 1'b0;
        soft_rst   = 1'b0;
        st_wr_en   = 1'b0;

        unique case (s1_op_reg)
            OP_READ:
            begin
                unique case (s1_idx_reg)
                    R_REV:            rd_val = REV_VAL;
                    R_CTRL:           rd_val = ctrl_reg;
                    R_CMD:            rd_val = {28'd0, cmd_reg};
                    R_IST:            rd_val = {29'd0, sf_reg, 2'd0};
                    R_IEN, R_IDIS:    rd_val = ien_reg;
                    R_HCCA:           rd_val = {hcca_reg, 8'd0};
                    R_CHED:           rd_val = {ched_reg, 4'd0};
                    R_CCED:           rd_val = {cced_reg, 4'd0};
                    R_BHED:           rd_val = {bhed_reg, 4'd0};
                    R_BCED:           rd_val = {bced_reg, 4'd0};
                    R_PCED, R_DONE, R_FMN: rd_val = 32'd0;
                    R_FMI:            rd_val = fmi_reg;
                    R_FMR:
                    begin
                        // live countdown only while operational; wraps in 14 bits
                        if (ctrl_reg[7:6] == HCFS_OPER)
                        begin
                            rd_val = {18'd0, fmi_reg[ELAPSED_W-1:0] - elap_reg};
                        end
                        else
                        begin
                            rd_val = {18'd0, fmr_reg};
                        end
                    end
                    R_PSTRT:          rd_val = pstrt_reg;
                    R_LST:            rd_val = lst_reg;
                    R_RHDA:           rd_val = rhda_reg;
                    R_RHDB:           rd_val = rhdb_reg;
                    R_RHST:           rd_val = {16'd0, drwe_reg, 15'd0};
                    default:          rd_val = port_hit ? port_reg[pidx] : st_rdata;
                endcase
            end

            OP_WRITE:
            begin
                unique case (s1_idx_reg)
                    R_REV, R_PCED, R_DONE, R_FMR, R_FMN:
                    begin
                        // read-only words
                    end
                    R_CTRL:
                    begin
                        ctrl_next = v;
                        if (ctrl_reg[7:6] != v[7:6])
                        begin
                            if (v[7:6] == HCFS_RESET)
                            begin
                                hard_rst = 1'b1;
                            end
                            else if (v[7:6] == HCFS_OPER)
                            begin
                                // frame starts: reload remaining, raise SF
                                elap_next = '0;
                                run_next  = 1'b1;
                                fmr_next  = fmi_reg[ELAPSED_W-1:0];
                                sf_next   = 1'b1;
                                irq_next  = ien_reg[31] && ien_reg[2];
                            end
                            else
                            begin
                                run_next = 1'b0;
                            end
                        end
                    end
                    R_CMD:
                    begin
                        cmd_next = cmd_reg | v[3:0];
                        soft_rst = v[0];
                    end
                    R_IST:
                    begin
                        sf_next  = sf_reg && !v[2];
                        irq_next = ien_reg[31] && ien_reg[2] && sf_reg && !v[2];
                    end
                    R_IEN:
                    begin
                        ien_next = ien_reg | v;
                        irq_next = (ien_reg[31] || v[31]) && (ien_reg[2] || v[2]) && sf_reg;
                    end
                    R_IDIS:
                    begin
                        ien_next = ien_reg & ~v;
                        irq_next = ien_reg[31] && !v[31] && ien_reg[2] && !v[2] && sf_reg;
                    end
                    R_HCCA:  hcca_next  = v[31:8];
                    R_CHED:  ched_next  = v[31:4];
                    R_CCED:  cced_next  = v[31:4];
                    R_BHED:  bhed_next  = v[31:4];
                    R_BCED:  bced_next  = v[31:4];
                    R_FMI:   fmi_next   = v;
                    R_PSTRT: pstrt_next = v;
                    R_LST:   lst_next   = v;
                    R_RHDA:
                    begin
                        // NDP and bit 10 are read-only
                        rhda_next = {v[31:11], rhda_reg[10], v[9:8], rhda_reg[7:0]};
                    end
                    R_RHDB:  rhdb_next  = v;
                    R_RHST:
                    begin
                        // LPS clears power, LPSC sets it; set wins when both given
                        if (pwr_ok && (v[0] || v[16]))
                        begin
                            for (int p = 0; p < NP; p++)
                            begin
                                if (!(rhda_reg[8] && rhdb_reg[17 + p]))
                                begin
                                    port_next[p][8] = v[16];
                                end
                            end
                        end
                        if (v[31])
                        begin
                            drwe_next = 1'b0;
                        end
                        else if (v[15])
                        begin
                            drwe_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (port_hit)
                        begin
                            port_next[pidx] = v;
                        end
                        else
                        begin
                            st_wr_en = 1'b1;
                        end
                    end
                endcase
            end

            OP_TICK:
            begin
                if (run_reg)
                begin
                    if (elap_inc >= (ELAPSED_W+1)'(BIT_TIMES_PER_FRAME))
                    begin
                        elap_next = '0;
                    end
                    else
                    begin
                        elap_next = elap_inc[ELAPSED_W-1:0];
                    end
                end
            end

            default:
            begin
                // unused opcode: no effect
            end
        endcase

        // soft reset: words up to LSThreshold back to defaults, suspend
        if (soft_rst)
        begin
            ctrl_next  = {24'd0, HCFS_SUSP, 6'd0};
            cmd_next   = '0;
            sf_next    = 1'b0;
            ien_next   = '0;
            hcca_next  = '0;
            ched_next  = '0;
            cced_next  = '0;
            bhed_next  = '0;
            bced_next  = '0;
            fmi_next   = FMI_DEF;
            fmr_next   = '0;
            pstrt_next = '0;
            lst_next   = LST_DEF;
            run_next   = 1'b0;
        end

        // hard reset via HCFS: whole register file back to power-up values,
        // written Control value dropped, elapsed count and irq kept
        if (hard_rst)
        begin
            ctrl_next  = '0;
            cmd_next   = '0;
            sf_next    = 1'b0;
            ien_next   = '0;
            hcca_next  = '0;
            ched_next  = '0;
            cced_next  = '0;
            bhed_next  = '0;
            bced_next  = '0;
            fmi_next   = FMI_DEF;
            fmr_next   = '0;
            pstrt_next = '0;
            lst_next   = LST_DEF;
            rhda_next  = RHDA_DEF;
            rhdb_next  = '0;
            drwe_next  = 1'b0;
            for (int p = 0; p < NP; p++)
            begin
                port_next[p] = '0;
            end
            run_next   = 1'b0;
        end
    end

    assign st_clr = hard_rst;

    assign st_wr.en   = s1_fire && st_wr_en;
    assign st_wr.clr  = s1_fire && st_clr;
    assign st_wr.idx  = s1_idx_reg;
    assign st_wr.data = v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg  <= '0;
            cmd_reg   <= '0;
            sf_reg    <= 1'b0;
            ien_reg   <= '0;
            hcca_reg  <= '0;
            ched_reg  <= '0;
            cced_reg  <= '0;
            bhed_reg  <= '0;
            bced_reg  <= '0;
            fmi_reg   <= FMI_DEF;
            fmr_reg   <= '0;
            pstrt_reg <= '0;
            lst_reg   <= LST_DEF;
            rhda_reg  <= RHDA_DEF;
            rhdb_reg  <= '0;
            drwe_reg  <= 1'b0;
            for (int p = 0; p < NP; p++)
            begin
                port_reg[p] <= '0;
            end
            run_reg   <= 1'b0;
            elap_reg  <= '0;
            irq_reg   <= 1'b0;
        end
        else if (s1_fire)
        begin
            ctrl_reg  <= ctrl_next;
            cmd_reg   <= cmd_next;
            sf_reg    <= sf_next;
            ien_reg   <= ien_next;
            hcca_reg  <= hcca_next;
            ched_reg  <= ched_next;
            cced_reg  <= cced_next;
            bhed_reg  <= bhed_next;
            bced_reg  <= bced_next;
            fmi_reg   <= fmi_next;
            fmr_reg   <= fmr_next;
            pstrt_reg <= pstrt_next;
            lst_reg   <= lst_next;
            rhda_reg  <= rhda_next;
            rhdb_reg  <= rhdb_next;
            drwe_reg  <= drwe_next;
            port_reg  <= port_next;
            run_reg   <= run_next;
            elap_reg  <= elap_next;
            irq_reg   <= irq_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_irq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_data_reg <= rd_val;
            out_irq_reg  <= irq_next;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.irq_level = out_irq_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_elapsed_range: assert property (@(posedge clk) disable iff (!rst_n)
        elap_reg < (ELAPSED_W+1)'(BIT_TIMES_PER_FRAME))
        else $error("frame counter beyond frame length");

    a_hcfs_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_op_reg == OP_WRITE && s1_idx_reg == R_CTRL &&
         s1_data_reg[7:6] == HCFS_RESET && ctrl_reg[7:6] != HCFS_RESET)
        |=> (ctrl_reg == 32'd0 && !run_reg && rhda_reg == RHDA_DEF))
        else $error("entering reset state did not restore defaults");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (s1_valid_reg && rsp.valid && !rsp.ready))
        else $error("request stalled without a blocked response");

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for the OHCI host controller register file.
// A table of directed transactions, then random register traffic, checked against a
// cycle-free model of the register store. Needs ohcihc_pkg, ohcihc_if and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import ohcihc_pkg::*;

    // ------------------------------------------------------------------
    // Local codes and bit masks (OHCI register layout)
    // ------------------------------------------------------------------
    localparam logic [1:0]       OP_NONE     = 2'd3;      // undefined opcode, no effect
    localparam logic [1:0]       HCFS_RESUME = 2'd1;
    localparam logic [IDX_W-1:0] R_TOP       = 6'd63;     // last word of the aperture

    localparam int          NPORTS     = DEF_NUM_PORTS;
    localparam int          FRAME_BITS = DEF_BIT_TIMES;

    localparam logic [31:0] FI_MASK   = 32'h0000_3FFF;
    localparam logic [31:0] FRT_BIT   = 32'h8000_0000;
    localparam logic [31:0] INT_SF    = 32'h0000_0004;
    localparam logic [31:0] INT_ALL   = 32'h4000_007F;
    localparam logic [31:0] INT_MIE   = 32'h8000_0000;
    localparam logic [31:0] RH_PER_PORT_SW = 32'h0000_0100;
    localparam logic [31:0] RHDA_RO   = 32'h0000_04FF;
    localparam logic [31:0] PORT_PPS  = 32'h0000_0100;
    localparam logic [31:0] CMD_HCR   = 32'h0000_0001;
    localparam logic [31:0] CMD_BITS  = 32'h0000_000F;
    localparam logic [31:0] HCCA_MASK = 32'hFFFF_FF00;
    localparam logic [31:0] ED_MASK   = 32'hFFFF_FFF0;
    localparam logic [31:0] CTRL_SUSP = 32'h0000_00C0;
    // RhStatus command bits
    localparam logic [31:0] RHST_LPS  = 32'h0000_0001;    // clear global power
    localparam logic [31:0] RHST_DRWE = 32'h0000_8000;    // device remote wakeup enable
    localparam logic [31:0] RHST_LPSC = 32'h0001_0000;    // set global power
    localparam logic [31:0] RHST_CRWE = 32'h8000_0000;    // clear remote wakeup enable
    localparam logic [31:0] RHST_CMDS = RHST_LPS | RHST_DRWE | RHST_LPSC | RHST_CRWE;

    localparam int MAX_REPORTS   = 200;
    localparam int RANDOM_ITEMS  = 400;
    localparam int QUIET_FROM    = 340;   // no idling on either side after this many
    localparam int DRAIN_CYCLES  = 8;

    // ------------------------------------------------------------------
    // Clock, reset, channels, DUT
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #6 clk = ~clk;

    ohcihc_req_if req_ch ();
    ohcihc_rsp_if rsp_ch ();

    ohci_host_controller_registers u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // ------------------------------------------------------------------
    // Register store model
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [31:0] rdata;
        logic        irq;
    } hc_resp_t;

    logic [31:0]          hc_regs [DEF_REG_WORDS];
    bit                   frame_run;
    logic [ELAPSED_W-1:0] bit_count;    // bit times into the current frame
    bit                   irq_q;

    hc_resp_t pending_responses [$];   // predicted read data / irq, oldest first
    int       mismatches = 0;
    int       accesses_done = 0;
    bit       quiet = 1'b0;            // final stretch: no idling on either side
    int       gap_odds = 4;            // 0: sender never idles, else 1-in-N per transaction

    function automatic void hc_defaults();
        hc_regs[R_REV] = REV_VAL;
        hc_regs[R_FMI] = FMI_DEF;
        hc_regs[R_LST] = LST_DEF;
    endfunction

    function automatic void hc_hard_reset();
        foreach (hc_regs[i])
            hc_regs[i] = '0;
        hc_defaults();
        hc_regs[R_RHDA] = RH_NO_PWR_SW | RH_NO_OC_PROT | 32'(NPORTS);
        frame_run = 1'b0;
    endfunction

    function automatic void hc_update_irq();
        logic [31:0] en;
        en = hc_regs[R_IEN];
        irq_q = ((en & INT_MIE) != 0) && ((hc_regs[R_IST] & en & INT_ALL) != 0);
    endfunction

    // global (NPS=0, PSM=0) or per-port (PSM=1) switching; ports masked by
    // RhDescriptorB.PPCM are left alone in per-port mode
    function automatic void hc_port_power(input bit on);
        logic [31:0] mode;
        int          w;
        mode = hc_regs[R_RHDA] & (RH_NO_PWR_SW | RH_PER_PORT_SW);
        if (mode != 0 && mode != RH_PER_PORT_SW)
            return;
        for (int p = 0; p < NPORTS; p++)
        begin
            w = R_PORT0 + p;
            if (mode == RH_PER_PORT_SW && hc_regs[R_RHDB][17 + p])
                continue;
            if (on)
                hc_regs[w] |= PORT_PPS;
            else
                hc_regs[w] &= ~PORT_PPS;
        end
    endfunction

    function automatic void hc_write(input logic [IDX_W-1:0] idx, input logic [31:0] v);
        logic [1:0] old_s;
        case (idx)
            R_REV, R_PCED, R_DONE, R_FMR, R_FMN: ;
            R_CTRL:
            begin
                old_s = hc_regs[R_CTRL][7:6];
                hc_regs[R_CTRL] = v;
                if (old_s != v[7:6])
                begin
                    if (v[7:6] == HCFS_RESET)
                        hc_hard_reset();          // irq deliberately left as is
                    else if (v[7:6] == HCFS_OPER)
                    begin
                        bit_count = '0;
                        frame_run = 1'b1;
                        hc_regs[R_FMR] = (hc_regs[R_FMR] & FRT_BIT) | (hc_regs[R_FMI] & FI_MASK);
                        hc_regs[R_IST] |= INT_SF;
                        hc_update_irq();
                    end
                    else
                        frame_run = 1'b0;
                end
            end
            R_CMD:
            begin
                hc_regs[R_CMD] |= v & CMD_BITS;
                if ((v & CMD_HCR) != 0)
                begin
                    // soft reset: operational words only, root hub untouched
                    for (int i = 0; i < int'(R_RHDA); i++)
                        hc_regs[i] = '0;
                    hc_defaults();
                    hc_regs[R_CTRL] |= CTRL_SUSP;
                    frame_run = 1'b0;
                end
            end
            R_IST:
            begin
                hc_regs[R_IST] &= ~v;
                hc_update_irq();
            end
            R_IEN:
            begin
                hc_regs[R_IEN] |= v;
                hc_update_irq();
            end
            R_IDIS:
            begin
                hc_regs[R_IEN] &= ~v;
                hc_update_irq();
            end
            R_HCCA:
                hc_regs[R_HCCA] = v & HCCA_MASK;
            R_CHED, R_CCED, R_BHED, R_BCED:
                hc_regs[idx] = v & ED_MASK;
            R_RHDA:
                hc_regs[R_RHDA] = (v & ~RHDA_RO) | (hc_regs[R_RHDA] & RHDA_RO);
            R_RHST:
            begin
                if ((v & RHST_LPS) != 0)
                    hc_port_power(1'b0);
                if ((v & RHST_LPSC) != 0)
                    hc_port_power(1'b1);
                if ((v & RHST_DRWE) != 0)
                    hc_regs[R_RHST] |= RHST_DRWE;
                if ((v & RHST_CRWE) != 0)
                    hc_regs[R_RHST] &= ~RHST_DRWE;
            end
            default:
                hc_regs[idx] = v;
        endcase
    endfunction

    function automatic logic [31:0] hc_read(input logic [IDX_W-1:0] idx);
        logic [ELAPSED_W-1:0] left;
        if (idx == R_IDIS)
            return hc_regs[R_IEN];
        if (idx == R_FMR)
        begin
            if (hc_regs[R_CTRL][7:6] != HCFS_OPER)
                return hc_regs[R_FMR];
            left = hc_regs[R_FMI][ELAPSED_W-1:0] - bit_count;   // wraps within 14 bits
            return (hc_regs[R_FMR] & FRT_BIT) | 32'(left);
        end
        return hc_regs[idx];
    endfunction

    function automatic hc_resp_t predict_register_access(input logic [1:0] op,
                                                         input logic [IDX_W-1:0] idx,
                                                         input logic [31:0] data);
        hc_resp_t r;
        r.rdata = '0;
        case (op)
            OP_READ:  r.rdata = hc_read(idx);
            OP_WRITE: hc_write(idx, data);
            OP_TICK:
                if (frame_run)
                begin
                    if (bit_count == ELAPSED_W'(FRAME_BITS - 1))
                        bit_count = '0;
                    else
                        bit_count = bit_count + 1'b1;
                end
            default: ;
        endcase
        r.irq = irq_q;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side: one transaction per call, optional idle burst first.
    // valid stays high between back-to-back transactions.
    // ------------------------------------------------------------------
    task automatic do_access(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                             input logic [31:0] data, input bit typed, input hc_resp_t typed_resp);
        hc_resp_t predicted;
        if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.opcode     <= 2'($urandom);
            req_ch.reg_index  <= IDX_W'($urandom);
            req_ch.write_data <= $urandom;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op;
        req_ch.reg_index  <= idx;
        req_ch.write_data <= data;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // accepted at this edge: advance the model
        predicted = predict_register_access(op, idx, data);
        pending_responses.push_back(typed ? typed_resp : predicted);
        if (op != OP_NONE)
            accesses_done++;
    endtask

    task automatic access(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                          input logic [31:0] data);
        do_access(op, idx, data, 1'b0, '0);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] rand_index();
        if ($urandom_range(0, 5) == 0)
            return IDX_W'($urandom_range(25, 63));
        return IDX_W'($urandom_range(0, 24));
    endfunction

    // ------------------------------------------------------------------
    // Directed table. Expected values are typed in where obvious from the
    // register map; typed=0 rows fall back on the model.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] idx;
        logic [31:0]      data;
        int               reps;
        bit               typed;
        logic [31:0]      rdata;
        logic             irq;
    } dir_row_t;

    localparam int DIR_ROWS = 23;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // reset values
        '{OP_READ,  R_REV,  32'h0, 1, 1'b1, REV_VAL, 1'b0},
        '{OP_READ,  R_FMI,  32'h0, 1, 1'b1, FMI_DEF, 1'b0},
        '{OP_READ,  R_RHDA, 32'h0, 1, 1'b1, RH_NO_PWR_SW | RH_NO_OC_PROT | 32'(NPORTS), 1'b0},
        // FmRemaining while not operational: stored word
        '{OP_READ,  R_FMR,  32'h0, 1, 1'b1, 32'h0, 1'b0},
        // Revision is read-only
        '{OP_WRITE, R_REV,  '1,    1, 1'b1, 32'h0, 1'b0},
        '{OP_READ,  R_REV,  32'h0, 1, 1'b1, REV_VAL, 1'b0},
        // top of the aperture, all data bits
        '{OP_WRITE, R_TOP,  '1,    1, 1'b1, 32'h0, 1'b0},
        '{OP_READ,  R_TOP,  32'h0, 1, 1'b1, '1, 1'b0},
        // undefined opcode does nothing
        '{OP_NONE,  R_TOP,  '1,    1, 1'b1, 32'h0, 1'b0},
        // enable SF with MIE, then go operational: SF pends, irq rises
        '{OP_WRITE, R_IEN,  INT_MIE | INT_SF, 1, 1'b1, 32'h0, 1'b0},
        '{OP_WRITE, R_CTRL, 32'h80, 1, 1'b1, 32'h0, 1'b1},
        '{OP_READ,  R_IDIS, 32'h0, 1, 1'b1, INT_MIE | INT_SF, 1'b1},
        '{OP_TICK,  R_REV,  32'h0, 3, 1'b1, 32'h0, 1'b1},
        '{OP_READ,  R_FMR,  32'h0, 1, 1'b1, 32'h2EDC, 1'b1},
        // shrink FI below the elapsed count: remaining wraps in 14 bits
        '{OP_WRITE, R_FMI,  32'h2, 1, 1'b1, 32'h0, 1'b1},
        '{OP_READ,  R_FMR,  32'h0, 1, 1'b1, 32'h3FFF, 1'b1},
        // soft reset: Control to suspend, irq left alone, upper words kept
        '{OP_WRITE, R_CMD,  CMD_HCR, 1, 1'b1, 32'h0, 1'b1},
        '{OP_READ,  R_CTRL, 32'h0, 1, 1'b1, CTRL_SUSP, 1'b1},
        '{OP_READ,  R_CMD,  32'h0, 1, 1'b1, 32'h0, 1'b1},
        '{OP_READ,  R_TOP,  32'h0, 1, 1'b1, '1, 1'b1},
        // entering reset state: whole store back to defaults, irq not recomputed
        '{OP_WRITE, R_CTRL, 32'h0, 1, 1'b1, 32'h0, 1'b1},
        '{OP_READ,  R_TOP,  32'h0, 1, 1'b1, 32'h0, 1'b1},
        '{OP_WRITE, R_IST,  32'h0, 1, 1'b1, 32'h0, 1'b0}
    };

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        logic [31:0] d;
        int          n;

        req_ch.valid      <= 1'b0;
        req_ch.opcode     <= OP_READ;
        req_ch.reg_index  <= R_REV;
        req_ch.write_data <= '0;

        hc_hard_reset();
        bit_count = '0;
        irq_q     = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
            for (int k = 0; k < DIR_TABLE[r].reps; k++)
                do_access(DIR_TABLE[r].op, DIR_TABLE[r].idx, DIR_TABLE[r].data,
                          DIR_TABLE[r].typed, {DIR_TABLE[r].rdata, DIR_TABLE[r].irq});

        // random traffic: mostly short register sequences that get the
        // controller operational, switch ports, raise and clear interrupts
        accesses_done = 0;
        while (accesses_done < RANDOM_ITEMS)
        begin
            quiet = (accesses_done >= QUIET_FROM);
            case ($urandom_range(0, 3))
                0:       gap_odds = 0;
                1:       gap_odds = 3;
                default: gap_odds = 6;
            endcase

            case ($urandom_range(0, 7))
                0, 1:
                begin
                    // noise
                    n = $urandom_range(0, 9);
                    access((n < 4) ? OP_READ : (n < 8) ? OP_WRITE : (n == 8) ? OP_TICK : OP_NONE,
                           rand_index(), rand_word());
                end
                2:
                begin
                    // frame: optional small FI, leave then re-enter operational, tick, read
                    if ($urandom_range(0, 1))
                    begin
                        d = $urandom;
                        d[13:0] = 14'($urandom_range(0, 40));
                        access(OP_WRITE, R_FMI, d);
                    end
                    d = $urandom;
                    d[7:6] = $urandom_range(0, 1) ? HCFS_RESUME : HCFS_SUSP;
                    access(OP_WRITE, R_CTRL, d);
                    d = $urandom;
                    d[7:6] = HCFS_OPER;
                    access(OP_WRITE, R_CTRL, d);
                    repeat ($urandom_range(1, 40)) access(OP_TICK, rand_index(), $urandom);
                    access(OP_READ, R_FMR, $urandom);
                    access(OP_READ, R_IST, $urandom);
                end
                3:
                begin
                    // interrupt enables and status
                    access(OP_WRITE, R_IEN, rand_word() | ($urandom_range(0, 1) ? INT_MIE : 32'h0));
                    access(OP_READ, R_IST, $urandom);
                    access(OP_WRITE, R_IST, rand_word());
                    access(OP_READ, R_IDIS, $urandom);
                    if ($urandom_range(0, 1))
                        access(OP_WRITE, R_IDIS, rand_word());
                    access(OP_READ, R_IEN, $urandom);
                end
                4:
                begin
                    // root hub power switching
                    d = $urandom;
                    d[9:8] = 2'($urandom);          // NPS and PSM
                    access(OP_WRITE, R_RHDA, d);
                    access(OP_WRITE, R_RHDB, rand_word());
                    d = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom & RHST_CMDS);
                    access(OP_WRITE, R_RHST, d);
                    for (int p = 0; p < NPORTS; p++)
                        access(OP_READ, IDX_W'(R_PORT0 + p), $urandom);
                    access(OP_READ, R_RHST, $urandom);
                    access(OP_READ, R_RHDA, $urandom);
                end
                5:
                begin
                    // command status, soft reset now and then
                    d = rand_word();
                    d[0] = ($urandom_range(0, 2) == 0);
                    access(OP_WRITE, R_CMD, d);
                    access(OP_READ, IDX_W'($urandom_range(0, 20)), $urandom);
                    access(OP_READ, R_CMD, $urandom);
                end
                6:
                begin
                    // pointers and plain words: write then read back
                    case ($urandom_range(0, 7))
                        0: n = R_HCCA;
                        1: n = R_CHED;
                        2: n = R_CCED;
                        3: n = R_BHED;
                        4: n = R_BCED;
                        5: n = R_PSTRT;
                        6: n = R_LST;
                        default: n = $urandom_range(0, 63);
                    endcase
                    access(OP_WRITE, IDX_W'(n), rand_word());
                    access(OP_READ, IDX_W'(n), $urandom);
                end
                default:
                begin
                    // any functional state change, reset state included
                    access(OP_WRITE, R_CTRL, rand_word());
                    access(OP_READ, R_CTRL, $urandom);
                    access(OP_READ, R_FMR, $urandom);
                end
            endcase
        end

        req_ch.valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Response side: check each transaction against the oldest prediction,
    // and stall ready in random bursts.
    // ------------------------------------------------------------------
    initial
    begin
        hc_resp_t want;
        int       stall_left;

        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_responses.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: response with nothing expected, read_data %h irq %b",
                                 $time, rsp_ch.read_data, rsp_ch.irq_level);
                end
                else
                begin
                    want = pending_responses.pop_front();
                    if (rsp_ch.read_data !== want.rdata)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: read_data expected %h actual %h",
                                     $time, want.rdata, rsp_ch.read_data);
                    end
                    if (rsp_ch.irq_level !== want.irq)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: irq_level expected %b actual %b",
                                     $time, want.irq, rsp_ch.irq_level);
                    end
                end
            end

            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 6);
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Watchdog: stops a run that hangs and reports it as mismatches
    initial
    begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
